// File: rtl/core/cfa_pkg.sv
// Shared types and codes for the contiguous frame allocator.
// Holds the request and result word layouts, request kinds, status codes and frame states.
// No dependencies.
package cfa_pkg;

  localparam int unsigned FS_W = 2;

  typedef enum logic [1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_RESERVE = 2'd2,
    KIND_NOP     = 2'd3
  } cfa_kind_e;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_NOFIT   = 2'd1,
    STS_NOTHEAD = 2'd2,
    STS_OUTPOOL = 2'd3
  } cfa_status_e;

  // Frame state codes; the fourth code is never stored.
  typedef enum logic [FS_W-1:0] {
    FS_FREE   = 2'd0,
    FS_HEAD   = 2'd1,
    FS_FOLLOW = 2'd2
  } cfa_fstate_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [19:0] first_frame;
    logic [12:0] frame_count;
  } cfa_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [19:0] run_start;
    logic [12:0] free_count;
  } cfa_out_t;

endpackage

// File: rtl/core/contiguous_frame_allocator.sv
// First-fit contiguous frame allocator: top level with sequencer and configuration port.
// Depends on cfa_pkg and cfa_frame_ram.
//
// Usage: software sends one request word on the in channel (allocate a run,
// release a run by its head frame, reserve a given range) and takes one result
// word on the out channel: status, start frame of an allocated run, and the
// free-frame count after the request. Both channels use valid/stall; the block
// stalls its input while a request is in work and takes the next one as soon
// as the previous result sits in the output register, even if not yet taken.
// Requests rejected by range checks go straight to the result push. An allocate
// scans the pool for the first free run and then marks it; a release frees the
// head and its followers; a reserve checks its range and then marks it. During a
// scan the single read port of the frame-state store is read one frame per cycle.
// Reset and every write of pool_frames start a clearing pass that marks every
// frame free; no request is taken during it, but configuration writes are.
// The pool base may be rewritten at any idle time and only moves the pool. When
// the receiver stalls, a finished result waits in the output register and the
// block holds a later result until that one is taken.
module contiguous_frame_allocator #(
  parameter int unsigned MAX_FRAMES = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // request channel
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  cfa_pkg::cfa_in_t in_word_i,
  // result channel
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output cfa_pkg::cfa_out_t out_word_o
);
  import cfa_pkg::*;

  localparam int unsigned IW = $clog2(MAX_FRAMES);
  localparam int unsigned NW = $clog2(MAX_FRAMES + 1);
  localparam logic [12:0] RESET_POOL = 13'd4096;
  localparam logic        REG_POOL_BASE   = 1'b0;
  localparam logic        REG_POOL_FRAMES = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_MARK,
    S_PUSH
  } state_e;

  // Effective pool size: pool_frames capped at the store depth.
  function automatic logic [NW-1:0] eff_size(input logic [12:0] p);
    logic [NW-1:0] r;
    if (20'(p) >= 20'(MAX_FRAMES)) begin
      r = NW'(MAX_FRAMES);
    end else begin
      r = NW'(p);
    end
    return r;
  endfunction

  state_e      state_q, state_d;
  logic [19:0] pool_base_q, pool_base_d;
  logic [12:0] pool_frames_q, pool_frames_d;
  logic [12:0] free_total_q, free_total_d;
  logic [1:0]  kind_q, kind_d;
  logic [NW-1:0] rd_q, rd_d;       // next frame to read
  logic [NW-1:0] didx_q, didx_d;   // frame whose data returns this cycle
  logic          dv_q, dv_d;       // read data valid
  logic [NW-1:0] lim_q, lim_d;     // scan end, exclusive
  logic [NW-1:0] run_q, run_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic [NW-1:0] at_q, at_d;
  logic [NW-1:0] idx_q, idx_d;     // clear / mark sweep counter
  logic          first_q, first_d;
  logic [1:0]    res_status_q, res_status_d;
  logic [19:0]   res_start_q, res_start_d;
  logic          out_valid_q, out_valid_d;
  cfa_out_t      out_word_q, out_word_d;

  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [FS_W-1:0] mem_wdata;
  logic [FS_W-1:0] mem_rdata;

  logic          cfg_wr;
  logic [NW-1:0] pool_n;
  logic [20:0]   rel_diff;
  logic          in_pool;
  logic [NW-1:0] in_off;
  logic          past_end;
  logic          in_acc;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_POOL_FRAMES) ? 32'(pool_frames_q) : 32'(pool_base_q);

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  assign pool_n   = eff_size(pool_frames_q);
  assign rel_diff = {1'b0, in_word_i.first_frame} - {1'b0, pool_base_q};
  assign in_pool  = !rel_diff[20] && (rel_diff[19:0] < 20'(pool_n));
  assign in_off   = NW'(rel_diff[19:0]);
  assign past_end = (21'(rel_diff[19:0]) + 21'(in_word_i.frame_count)) > 21'(pool_n);

  cfa_frame_ram #(
    .DEPTH(MAX_FRAMES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(rd_q[IW-1:0]),
    .rdata_o(mem_rdata)
  );

  always_comb begin
    logic          last;
    logic [NW-1:0] run_nx;
    state_d       = state_q;
    pool_base_d   = pool_base_q;
    pool_frames_d = pool_frames_q;
    free_total_d  = free_total_q;
    kind_d        = kind_q;
    rd_d          = rd_q;
    didx_d        = didx_q;
    dv_d          = 1'b0;
    lim_d         = lim_q;
    run_d         = run_q;
    cnt_d         = cnt_q;
    at_d          = at_q;
    idx_d         = idx_q;
    first_d       = first_q;
    res_status_d  = res_status_q;
    res_start_d   = res_start_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_word_d    = out_word_q;
    mem_we        = 1'b0;
    mem_waddr     = idx_q[IW-1:0];
    mem_wdata     = FS_FREE;
    last          = (didx_q + NW'(1)) == lim_q;
    run_nx        = '0;

    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q[IW-1:0];
        mem_wdata = FS_FREE;
        idx_d     = idx_q + NW'(1);
        if (idx_q == NW'(MAX_FRAMES - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_acc) begin
          kind_d       = in_word_i.kind;
          first_d      = 1'b1;
          run_d        = '0;
          res_start_d  = '0;
          res_status_d = STS_OK;
          unique case (in_word_i.kind)
            KIND_ALLOC: begin
              if (in_word_i.frame_count != '0 &&
                  20'(in_word_i.frame_count) <= 20'(pool_n)) begin
                rd_d    = '0;
                lim_d   = pool_n;
                cnt_d   = NW'(in_word_i.frame_count);
                state_d = S_SCAN;
              end else begin
                res_status_d = STS_NOFIT;
                state_d      = S_PUSH;
              end
            end
            KIND_RELEASE: begin
              if (!in_pool) begin
                res_status_d = STS_OUTPOOL;
                state_d      = S_PUSH;
              end else begin
                rd_d    = in_off;
                lim_d   = pool_n;
                state_d = S_SCAN;
              end
            end
            KIND_RESERVE: begin
              if (!in_pool || past_end) begin
                res_status_d = STS_OUTPOOL;
                state_d      = S_PUSH;
              end else if (in_word_i.frame_count == '0) begin
                state_d = S_PUSH;
              end else begin
                rd_d    = in_off;
                at_d    = in_off;
                cnt_d   = NW'(in_word_i.frame_count);
                lim_d   = in_off + NW'(in_word_i.frame_count);
                state_d = S_SCAN;
              end
            end
            default: begin
              state_d = S_PUSH;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Issue one read a cycle; act on the data of the previous read.
        if (rd_q < lim_q) begin
          dv_d   = 1'b1;
          didx_d = rd_q;
          rd_d   = rd_q + NW'(1);
        end
        if (dv_q) begin
          unique case (kind_q)
            KIND_ALLOC: begin
              run_nx = (mem_rdata == FS_FREE) ? run_q + NW'(1) : '0;
              run_d  = run_nx;
              if (run_nx == cnt_q) begin
                at_d    = didx_q + NW'(1) - cnt_q;
                state_d = S_MARK;
              end else if (last) begin
                res_status_d = STS_NOFIT;
                state_d      = S_PUSH;
              end
            end
            KIND_RESERVE: begin
              if (mem_rdata != FS_FREE) begin
                res_status_d = STS_NOFIT;
                state_d      = S_PUSH;
              end else if (last) begin
                state_d = S_MARK;
              end
            end
            default: begin
              // Release: free the head, then every follower after it.
              first_d = 1'b0;
              if ((first_q && mem_rdata == FS_HEAD) ||
                  (!first_q && mem_rdata == FS_FOLLOW)) begin
                mem_we       = 1'b1;
                mem_waddr    = didx_q[IW-1:0];
                mem_wdata    = FS_FREE;
                free_total_d = free_total_q + 13'd1;
                if (last) begin
                  state_d = S_PUSH;
                end
              end else begin
                if (first_q) begin
                  res_status_d = STS_NOTHEAD;
                end
                state_d = S_PUSH;
              end
            end
          endcase
          if (state_d != S_SCAN) begin
            dv_d = 1'b0;
          end
          if (state_d == S_MARK) begin
            idx_d        = '0;
            free_total_d = free_total_q - 13'(cnt_q);
          end
        end
      end

      S_MARK: begin
        mem_we    = 1'b1;
        mem_waddr = IW'(at_q + idx_q);
        mem_wdata = (idx_q == '0) ? FS_HEAD : FS_FOLLOW;
        idx_d     = idx_q + NW'(1);
        if ((idx_q + NW'(1)) == cnt_q) begin
          if (kind_q == KIND_ALLOC) begin
            res_start_d = pool_base_q + 20'(at_q);
          end
          state_d = S_PUSH;
        end
      end

      S_PUSH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d            = 1'b1;
          out_word_d.status      = res_status_q;
          out_word_d.run_start   = res_start_q;
          out_word_d.free_count  = free_total_q;
          state_d                = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // The user must issue configuration writes only while idle; the block itself does not enforce this.
    if (cfg_wr) begin
      if (paddr[2] == REG_POOL_BASE) begin
        pool_base_d = pwdata[19:0];
      end else begin
        pool_frames_d = pwdata[12:0];
        free_total_d  = 13'(eff_size(pwdata[12:0]));
        idx_d         = '0;
        state_d       = S_CLEAR;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLEAR;
      pool_base_q   <= '0;
      pool_frames_q <= RESET_POOL;
      free_total_q  <= 13'(eff_size(RESET_POOL));
      idx_q         <= '0;
      dv_q          <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      pool_base_q   <= pool_base_d;
      pool_frames_q <= pool_frames_d;
      free_total_q  <= free_total_d;
      idx_q         <= idx_d;
      dv_q          <= dv_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Payload and datapath registers.
  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    rd_q         <= rd_d;
    didx_q       <= didx_d;
    lim_q        <= lim_d;
    run_q        <= run_d;
    cnt_q        <= cnt_d;
    at_q         <= at_d;
    first_q      <= first_d;
    res_status_q <= res_status_d;
    res_start_q  <= res_start_d;
    out_word_q   <= out_word_d;
  end

endmodule

// File: rtl/core/cfa_frame_ram.sv
// Frame-state store: one write port, one read port, registered read data.
// Depends on cfa_pkg for the state width.
module cfa_frame_ram #(
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [cfa_pkg::FS_W-1:0] wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [cfa_pkg::FS_W-1:0] rdata_o
);
  import cfa_pkg::*;

  logic [FS_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
